// ===== hdl/pl0x_pkg.sv =====
// ----------------------------------------------------------------------------
// pl0x_pkg
// Shared types and opcode constants for the P-code execute block.
// ----------------------------------------------------------------------------
`default_nettype none
package pl0x_pkg;
    typedef struct packed {
        logic [3:0]  func;
        logic [2:0]  level;
        logic [15:0] operand;
        logic signed [31:0] read_value;
    } t_instr;

    typedef struct packed {
        logic [8:0]  next_pc;
        logic [10:0] base_out;
        logic [10:0] top_out;
        logic        write_valid;
        logic signed [31:0] write_value;
        logic        halted;
        logic [1:0]  status;
    } t_result;

    localparam logic [3:0] F_LIT = 4'd1;
    localparam logic [3:0] F_OPR = 4'd2;
    localparam logic [3:0] F_LOD = 4'd3;
    localparam logic [3:0] F_STO = 4'd4;
    localparam logic [3:0] F_CAL = 4'd5;
    localparam logic [3:0] F_INC = 4'd6;
    localparam logic [3:0] F_JMP = 4'd7;
    localparam logic [3:0] F_JPC = 4'd8;
    localparam logic [3:0] F_OUT = 4'd9;
    localparam logic [3:0] F_IN  = 4'd10;

    localparam logic [15:0] O_RET = 16'd0;
    localparam logic [15:0] O_NEG = 16'd1;
    localparam logic [15:0] O_ADD = 16'd2;
    localparam logic [15:0] O_SUB = 16'd3;
    localparam logic [15:0] O_MUL = 16'd4;
    localparam logic [15:0] O_DIV = 16'd5;
    localparam logic [15:0] O_ODD = 16'd6;
    localparam logic [15:0] O_MOD = 16'd7;
    localparam logic [15:0] O_EQL = 16'd8;
    localparam logic [15:0] O_NEQ = 16'd9;
    localparam logic [15:0] O_LSS = 16'd10;
    localparam logic [15:0] O_LEQ = 16'd11;
    localparam logic [15:0] O_GTR = 16'd12;
    localparam logic [15:0] O_GEQ = 16'd13;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ILL   = 2'd1;
    localparam logic [1:0] ST_DIVZ  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam int PtrW = 11;
    localparam int PcW  = 9;
    // Code space size; program counter values are reduced modulo this.
    localparam int CodeDepth = 512;
endpackage
`default_nettype wire

// ===== hdl/pl0x_stream_if.sv =====
// ----------------------------------------------------------------------------
// pl0x_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
`default_nettype none
interface pl0x_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pl0_stack_machine_execute.sv =====
// ----------------------------------------------------------------------------
// pl0_stack_machine_execute
// PL/0 P-code execute unit with the stack held in one synchronous RAM.
// ----------------------------------------------------------------------------
// One instruction is accepted per transaction and runs as a short sequence of
// single-port stack RAM accesses (one read or one write per cycle, read data
// returned in the following cycle). After reset a clearing pass writes zero to
// every stack word, during which no instruction is accepted. LOD, STO and CAL
// first follow one static link per level; DIV and MOD run a bit-serial 32-step
// divider, skipped when the divisor is zero. The result sits in an output
// register; the next instruction is taken the cycle after that result has been
// passed on. The code space is fixed at 512 words (package constant).
`default_nettype none
module pl0_stack_machine_execute #(
    parameter int STACK_DEPTH = 2048,
    parameter int MAX_LEVELS  = 7
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pl0x_stream_if.sink   i_instr,
    pl0x_stream_if.source o_result
);
    import pl0x_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(MAX_LEVELS + 1);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_WALK  = 13'b0000000000100,
        S_WWAIT = 13'b0000000001000,
        S_RD0   = 13'b0000000010000,
        S_RD0W  = 13'b0000000100000,
        S_RD1   = 13'b0000001000000,
        S_RD1W  = 13'b0000010000000,
        S_DIV   = 13'b0000100000000,
        S_WR0   = 13'b0001000000000,
        S_WR1   = 13'b0010000000000,
        S_WR2   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    // Stack RAM.
    logic [31:0] r_mem [STACK_DEPTH];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    t_state r_state;
    t_instr r_ins;
    logic [PtrW-1:0] r_sp, r_bp;
    logic [PcW-1:0]  r_pc;
    logic [PtrW-1:0] r_b;       // walked base
    logic [LW-1:0]   r_lev;
    logic [31:0]     r_x, r_y;  // operands
    logic            r_rerr, r_divz, r_ill;
    logic [AW:0]     r_clr;
    logic [16:0]     r_a0, r_a1, r_a2; // addresses (may be out of range)
    logic [31:0]     r_w0, r_w1, r_w2;
    logic [1:0]      r_nwr;
    logic            r_out_v;
    t_result         r_res;
    // divider
    logic [31:0] r_q, r_rem, r_dvs;
    logic [5:0]  r_dcnt;

    function automatic logic [PcW-1:0] pc_of(input logic [31:0] v);
        return PcW'(v % CodeDepth);
    endfunction

    function automatic logic in_rng(input logic [16:0] a);
        return 32'(a) < STACK_DEPTH;
    endfunction

    function automatic logic [31:0] alu_next(input logic [15:0] op,
                                             input logic [31:0] x,
                                             input logic [31:0] y);
        logic signed [31:0] a, b;
        a = x;
        b = y;
        case (op)
            O_ADD: return x + y;
            O_SUB: return x - y;
            O_MUL: return x * y;
            O_EQL: return 32'(a == b);
            O_NEQ: return 32'(a != b);
            O_LSS: return 32'(a < b);
            O_LEQ: return 32'(a <= b);
            O_GTR: return 32'(a > b);
            default: return 32'(a >= b);
        endcase
    endfunction

    logic [16:0] walk_addr;
    assign walk_addr = 17'(r_b) + 17'd1;

    assign i_instr.ready  = (r_state == S_IDLE) && !r_out_v;
    assign o_result.valid = r_out_v;
    assign o_result.data  = r_res;

    // Memory port: address from the current step.
    logic [16:0] cur_a;
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_w0;
        cur_a     = r_a0;
        unique case (r_state)
            S_CLEAR: begin
                cur_a = 17'(r_clr);
                mem_we = 1'b1;
                mem_wdata = '0;
            end
            S_WALK: cur_a = walk_addr;
            S_RD0:  cur_a = r_a0;
            S_RD1:  cur_a = r_a1;
            S_WR0: begin
                cur_a = r_a0;
                mem_we = in_rng(r_a0);
                mem_wdata = r_w0;
            end
            S_WR1: begin
                cur_a = r_a1;
                mem_we = in_rng(r_a1);
                mem_wdata = r_w1;
            end
            S_WR2: begin
                cur_a = r_a2;
                mem_we = in_rng(r_a2);
                mem_wdata = r_w2;
            end
            default: cur_a = r_a0;
        endcase
        mem_addr = AW'(cur_a);
    end

    // Read data of the first and second access; out-of-range reads give zero.
    logic [31:0] rd0_val, rd1_val;
    assign rd0_val = in_rng(r_a0) ? r_rdata : 32'd0;
    assign rd1_val = in_rng(r_a1) ? r_rdata : 32'd0;

    logic [32:0] dsub;
    logic [31:0] ax, ay;
    assign ax = r_x[31] ? (32'd0 - r_x) : r_x;
    assign ay = r_y[31] ? (32'd0 - r_y) : r_y;
    assign dsub = {r_rem[31:0], r_q[31]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_sp    <= '0;
            r_bp    <= PtrW'(1);
            r_pc    <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (o_result.valid && o_result.ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(STACK_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_instr.valid && i_instr.ready) begin
                        r_ins  <= i_instr.data;
                        r_pc   <= pc_of(32'(r_pc) + 32'd1);
                        r_b    <= r_bp;
                        r_lev  <= (32'(i_instr.data.level) < MAX_LEVELS) ?
                                  LW'(i_instr.data.level) : LW'(MAX_LEVELS);
                        r_rerr <= 1'b0;
                        r_divz <= 1'b0;
                        r_ill  <= 1'b0;
                        r_x    <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // Follow one static link per level until the level count hits zero.
                    if (r_lev == '0 || !(r_ins.func == F_LOD || r_ins.func == F_STO ||
                                          r_ins.func == F_CAL)) begin
                        // Set up access plan.
                        r_nwr <= 2'd0;
                        case (r_ins.func)
                            F_LIT, F_IN: begin
                                r_a0 <= 17'(PtrW'(r_sp + 1'b1));
                                r_w0 <= (r_ins.func == F_LIT) ? 32'(r_ins.operand)
                                                              : r_ins.read_value;
                                r_sp <= r_sp + 1'b1;
                                r_state <= S_WR0;
                            end
                            F_INC: begin
                                r_sp <= r_sp + PtrW'(r_ins.operand);
                                r_state <= S_DONE;
                            end
                            F_JMP: begin
                                r_pc <= pc_of(32'(r_ins.operand));
                                r_state <= S_DONE;
                            end
                            F_LOD: begin
                                r_a0 <= 17'(r_b) + 17'(r_ins.operand);
                                r_state <= S_RD0;
                            end
                            F_STO, F_JPC, F_OUT: begin
                                r_a0 <= 17'(r_sp);
                                r_state <= S_RD0;
                            end
                            F_CAL: begin
                                r_a0 <= 17'(r_sp) + 17'd1;
                                r_w0 <= '0;
                                r_a1 <= 17'(r_sp) + 17'd2;
                                r_w1 <= 32'(r_b);
                                r_a2 <= 17'(r_sp) + 17'd3;
                                r_w2 <= 32'(r_bp);
                                r_state <= S_WR0;
                            end
                            F_OPR: begin
                                case (r_ins.operand)
                                    O_RET: begin
                                        r_sp <= r_bp - 1'b1;
                                        r_a0 <= 17'(PtrW'(r_bp - 1'b1)) + 17'd4;
                                        r_a1 <= 17'(PtrW'(r_bp - 1'b1)) + 17'd3;
                                        r_state <= S_RD0;
                                    end
                                    O_NEG, O_ODD: begin
                                        r_a0 <= 17'(r_sp);
                                        r_state <= S_RD0;
                                    end
                                    default: begin
                                        if (r_ins.operand > O_GEQ) begin
                                            r_ill <= 1'b1;
                                            r_state <= S_DONE;
                                        end else begin
                                            r_sp <= r_sp - 1'b1;
                                            r_a0 <= 17'(PtrW'(r_sp - 1'b1));
                                            r_a1 <= 17'(PtrW'(r_sp - 1'b1)) + 17'd1;
                                            r_state <= S_RD0;
                                        end
                                    end
                                endcase
                            end
                            default: begin
                                r_ill <= 1'b1;
                                r_state <= S_DONE;
                            end
                        endcase
                    end else begin
                        if (!in_rng(walk_addr)) begin
                            r_rerr <= 1'b1;
                        end
                        r_state <= S_WWAIT;
                    end
                end
                S_WWAIT: begin
                    // A call writes zero to the word above the stack top only after it walks;
                    // a link read of that word during a call is forced to zero here.
                    r_b   <= (!in_rng(r_a2) ||
                              (r_ins.func == F_CAL && r_a2 == 17'(r_sp) + 17'd1)) ?
                             '0 : PtrW'(r_rdata);
                    r_lev <= r_lev - 1'b1;
                    r_state <= S_WALK;
                end
                S_RD0: r_state <= S_RD0W;
                S_RD0W: begin
                    if (!in_rng(r_a0)) r_rerr <= 1'b1;
                    r_x <= rd0_val;
                    case (r_ins.func)
                        F_LOD: begin
                            r_sp <= r_sp + 1'b1;
                            r_a0 <= 17'(PtrW'(r_sp + 1'b1));
                            r_w0 <= rd0_val;
                            r_state <= S_WR0;
                        end
                        F_STO: begin
                            r_a0 <= 17'(r_b) + 17'(r_ins.operand);
                            r_w0 <= rd0_val;
                            r_sp <= r_sp - 1'b1;
                            r_state <= S_WR0;
                        end
                        F_JPC: begin
                            if (rd0_val == 32'd0) r_pc <= pc_of(32'(r_ins.operand));
                            r_sp <= r_sp - 1'b1;
                            r_state <= S_DONE;
                        end
                        F_OUT: begin
                            r_sp <= r_sp - 1'b1;
                            r_state <= S_DONE;
                        end
                        default: begin // OPR
                            case (r_ins.operand)
                                O_RET: begin
                                    r_pc <= pc_of(rd0_val);
                                    r_state <= S_RD1;
                                end
                                O_NEG: begin
                                    r_w0 <= 32'd0 - rd0_val;
                                    r_state <= S_WR0;
                                end
                                O_ODD: begin
                                    r_w0 <= rd0_val & 32'd1;
                                    r_state <= S_WR0;
                                end
                                default: r_state <= S_RD1;
                            endcase
                        end
                    endcase
                end
                S_RD1: r_state <= S_RD1W;
                S_RD1W: begin
                    if (!in_rng(r_a1)) r_rerr <= 1'b1;
                    if (r_ins.operand == O_RET) begin
                        r_bp <= PtrW'(rd1_val);
                        r_state <= S_DONE;
                    end else begin
                        r_y <= rd1_val;
                        if (r_ins.operand == O_DIV || r_ins.operand == O_MOD) begin
                            r_state <= S_DIV;
                            r_dcnt  <= '0;
                        end else begin
                            r_state <= S_WR0;
                        end
                    end
                end
                S_DIV: begin
                    // Restoring divide on magnitudes, one quotient bit a cycle.
                    if (r_dcnt == 6'd0) begin
                        if (r_y == 32'd0) begin
                            r_divz <= 1'b1;
                            r_w0 <= '0;
                            r_state <= S_WR0;
                        end else begin
                            r_q <= ax;
                            r_rem <= '0;
                            r_dvs <= ay;
                            r_dcnt <= 6'd1;
                        end
                    end else if (r_dcnt <= 6'd32) begin
                        if (!dsub[32]) begin
                            r_rem <= dsub[31:0];
                            r_q <= {r_q[30:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[30:0], r_q[31]};
                            r_q <= {r_q[30:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt + 1'b1;
                    end else begin
                        if (r_ins.operand == O_DIV) begin
                            r_w0 <= (r_x[31] ^ r_y[31]) ? 32'd0 - r_q : r_q;
                        end else begin
                            r_w0 <= r_x[31] ? 32'd0 - r_rem : r_rem;
                        end
                        r_state <= S_WR0;
                    end
                end
                S_WR0: begin
                    if (!in_rng(r_a0)) r_rerr <= 1'b1;
                    r_state <= (r_ins.func == F_CAL) ? S_WR1 : S_DONE;
                end
                S_WR1: begin
                    if (!in_rng(r_a1)) r_rerr <= 1'b1;
                    r_state <= S_WR2;
                end
                S_WR2: begin
                    if (!in_rng(r_a2)) r_rerr <= 1'b1;
                    if (r_nwr == 2'd0) begin
                        // Fourth frame word: return address.
                        r_nwr <= 2'd1;
                        r_a2 <= 17'(r_sp) + 17'd4;
                        r_w2 <= 32'(r_pc);
                    end else begin
                        r_bp <= r_sp + 1'b1;
                        r_pc <= pc_of(32'(r_ins.operand));
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_res.next_pc     <= r_pc;
                    r_res.base_out    <= r_bp;
                    r_res.top_out     <= r_sp;
                    r_res.write_valid <= (r_ins.func == F_OUT);
                    r_res.write_value <= (r_ins.func == F_OUT) ? r_x : '0;
                    r_res.halted      <= (r_bp == '0);
                    r_res.status      <= r_rerr ? ST_RANGE : r_divz ? ST_DIVZ :
                                         r_ill ? ST_ILL : ST_OK;
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // ALU result for two-operand ops other than divide and modulo.
            if (r_state == S_RD1W && r_ins.operand != O_RET &&
                r_ins.operand != O_DIV && r_ins.operand != O_MOD) begin
                r_w0 <= alu_next(r_ins.operand, r_x, rd1_val);
            end
            if (r_state == S_WALK && r_lev != '0) begin
                r_a2 <= walk_addr;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_instr.ready)
        else $error("instruction accepted during clear");
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !o_result.ready) |=> (r_out_v && $stable(r_res)))
        else $error("result dropped while stalled");
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_instr.valid && i_instr.ready) |=> !i_instr.ready)
        else $error("second instruction taken while busy");
`endif
endmodule
`default_nettype wire
